// ===== rtl/core/apf_pkg.sv =====
// ----------------------------------------------------------------------------
// apf_pkg
// Shared constants and controller/datapath interface types for the
// all-pole feedback filter.
// ----------------------------------------------------------------------------
package apf_pkg;

	// Fixed field and register widths.
	localparam int COEFF_W    = 18;
	localparam int FRAC_BITS  = 16;
	localparam int TAPS_W     = 3;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 18;

	// Register indexes on the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_TAPS    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COEFF_1 = 3'd1;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;    // capture the accepted item, apply clear
		logic mac;     // issue the multiply for the current tap
		logic finish;  // round, saturate, write output and history
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic last_tap;   // current tap is the last one in use
		logic out_stall;  // output register holds an item not yet taken
	} sts_t;

endpackage

// ===== rtl/core/apf_ctrl.sv =====
// ----------------------------------------------------------------------------
// apf_ctrl
// Sequencer for the feedback filter: accepts one item, steps the shared
// multiply-accumulate over the active taps, then hands the result to the
// output register.
// ----------------------------------------------------------------------------
module apf_ctrl
	import apf_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_MAC   = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;
	localparam logic [1:0] ST_FIN   = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;

	// Handshake and commands.
	assign in_ready   = (state_q == ST_IDLE);
	assign cmd.load   = in_valid && in_ready;
	assign cmd.mac    = (state_q == ST_MAC);
	assign cmd.finish = (state_q == ST_FIN) && !sts.out_stall;

	// Next-state logic.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd.load) state_d = ST_MAC;
			end
			ST_MAC: begin
				if (sts.last_tap) state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				state_d = ST_FIN;
			end
			ST_FIN: begin
				if (!sts.out_stall) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Multiplies start right after an item is taken.
	a_load_then_mac: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> cmd.mac)
		else $error("multiply sequence did not start after accept");

	// The last tap always leads to the drain step.
	a_last_tap_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MAC && sts.last_tap) |=> (state_q == ST_DRAIN))
		else $error("tap loop did not end on the last tap");

endmodule

// ===== rtl/core/apf_datapath.sv =====
// ----------------------------------------------------------------------------
// apf_datapath
// Configuration registers, output history, one registered multiplier with
// an accumulator, rounding and saturation, and the output register.
// ----------------------------------------------------------------------------
module apf_datapath
	import apf_pkg::*;
#(
	parameter int MAX_TAPS     = 6,
	parameter int SAMPLE_WIDTH = 24
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_write,
	input  logic [CFG_IDX_W-1:0]           cfg_index,
	input  logic [CFG_DATA_W-1:0]          cfg_data,
	input  logic signed [SAMPLE_WIDTH-1:0] sample_in,
	input  logic                           clear,
	input  cmd_t                           cmd,
	output sts_t                           sts,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic signed [SAMPLE_WIDTH-1:0] filtered_sample,
	output logic                           overflow
);

	localparam int IDX_W  = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
	localparam int PROD_W = COEFF_W + SAMPLE_WIDTH;
	localparam int ACC_W  = SAMPLE_WIDTH + COEFF_W + 3;
	localparam int YF_W   = ACC_W - FRAC_BITS;

	localparam logic signed [ACC_W-1:0] RND_HALF = 1 <<< (FRAC_BITS - 1);
	localparam logic signed [YF_W-1:0]  Y_MAX    =
		{{(YF_W - SAMPLE_WIDTH + 1){1'b0}}, {(SAMPLE_WIDTH - 1){1'b1}}};
	localparam logic signed [YF_W-1:0]  Y_MIN    =
		{{(YF_W - SAMPLE_WIDTH + 1){1'b1}}, {(SAMPLE_WIDTH - 1){1'b0}}};

	logic [TAPS_W-1:0]              taps_q;
	logic signed [COEFF_W-1:0]      coeff_q [MAX_TAPS];
	logic signed [SAMPLE_WIDTH-1:0] hist_q  [MAX_TAPS];
	logic [IDX_W-1:0]               wp_q;
	logic [IDX_W-1:0]               j_q;
	logic [IDX_W-1:0]               k_q;
	logic signed [ACC_W-1:0]        acc_q;
	logic signed [PROD_W-1:0]       prod_s1;
	logic                           prod_vld_s1;
	logic                           out_valid_q;
	logic signed [SAMPLE_WIDTH-1:0] out_sample_q;
	logic                           out_ovf_q;

	logic [TAPS_W-1:0]              eff_taps;
	logic [IDX_W-1:0]               eff_m1;
	logic [IDX_W-1:0]               wp_start;
	logic [TAPS_W-1:0]              wp_inc;
	logic [IDX_W-1:0]               wp_next;
	logic signed [PROD_W-1:0]       mult;
	logic signed [ACC_W-1:0]        rnd;
	logic signed [YF_W-1:0]         y_full;
	logic                           ovf_hi;
	logic                           ovf_lo;
	logic signed [SAMPLE_WIDTH-1:0] y_sat;

	// Tap count in use: zero counts as one, large values clamp to the maximum.
	always_comb begin
		if (taps_q == '0) begin
			eff_taps = TAPS_W'(1);
		end else if (taps_q > TAPS_W'(MAX_TAPS)) begin
			eff_taps = TAPS_W'(MAX_TAPS);
		end else begin
			eff_taps = taps_q;
		end
	end
	assign eff_m1 = IDX_W'(eff_taps - TAPS_W'(1));

	// Newest-entry position at the start of an item, after clear and wrap.
	assign wp_start = (clear || (TAPS_W'(wp_q) >= eff_taps)) ? '0 : wp_q;

	// Position of the entry written when the item finishes.
	assign wp_inc  = TAPS_W'(wp_q) + TAPS_W'(1);
	assign wp_next = (wp_inc >= eff_taps) ? '0 : IDX_W'(wp_inc);

	// Shared multiplier, registered before the accumulator.
	assign mult = coeff_q[k_q] * hist_q[j_q];

	// Round half up, then saturate to the sample range.
	assign rnd    = acc_q + RND_HALF;
	assign y_full = $signed(rnd[ACC_W-1:FRAC_BITS]);
	assign ovf_hi = (y_full > Y_MAX);
	assign ovf_lo = (y_full < Y_MIN);
	always_comb begin
		if (ovf_hi) begin
			y_sat = Y_MAX[SAMPLE_WIDTH-1:0];
		end else if (ovf_lo) begin
			y_sat = Y_MIN[SAMPLE_WIDTH-1:0];
		end else begin
			y_sat = y_full[SAMPLE_WIDTH-1:0];
		end
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			taps_q <= TAPS_W'(1);
			for (int i = 0; i < MAX_TAPS; i++) coeff_q[i] <= '0;
		end else if (cfg_write) begin
			if (cfg_index == REG_TAPS) taps_q <= cfg_data[TAPS_W-1:0];
			for (int i = 0; i < MAX_TAPS; i++) begin
				if (cfg_index == CFG_IDX_W'(REG_COEFF_1 + i)) begin
					coeff_q[i] <= $signed(cfg_data[COEFF_W-1:0]);
				end
			end
		end
	end

	// Output history and write position.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			for (int i = 0; i < MAX_TAPS; i++) hist_q[i] <= '0;
		end else if (cfg_write && cfg_index == REG_TAPS) begin
			wp_q <= '0;
			for (int i = 0; i < MAX_TAPS; i++) hist_q[i] <= '0;
		end else if (cmd.load) begin
			wp_q <= wp_start;
			if (clear) begin
				for (int i = 0; i < MAX_TAPS; i++) hist_q[i] <= '0;
			end
		end else if (cmd.finish) begin
			wp_q            <= wp_next;
			hist_q[wp_next] <= y_sat;
		end
	end

	// Tap walk and product pipeline.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prod_vld_s1 <= 1'b0;
		end else begin
			prod_vld_s1 <= cmd.mac;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			k_q <= '0;
			j_q <= wp_start;
		end else if (cmd.mac) begin
			k_q <= k_q + IDX_W'(1);
			j_q <= (j_q == '0) ? eff_m1 : j_q - IDX_W'(1);
		end
		if (cmd.mac) prod_s1 <= mult;
	end

	// Accumulator: seeded with the input sample in Q.16.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			acc_q <= ACC_W'(sample_in) <<< FRAC_BITS;
		end else if (prod_vld_s1) begin
			acc_q <= acc_q + ACC_W'(prod_s1);
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			out_sample_q <= y_sat;
			out_ovf_q    <= ovf_hi || ovf_lo;
		end
	end

	assign out_valid       = out_valid_q;
	assign filtered_sample = out_sample_q;
	assign overflow        = out_ovf_q;

	assign sts.last_tap  = (k_q == eff_m1);
	assign sts.out_stall = out_valid_q && !out_ready;

	// The write position always points inside the active part of the history.
	a_wp_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		TAPS_W'(wp_q) < eff_taps)
		else $error("write position outside active taps");

	// History reads stay inside the active taps.
	a_rd_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.mac |-> (TAPS_W'(j_q) < eff_taps))
		else $error("history read outside active taps");

	// No product is left pending when a new item seeds the accumulator.
	a_no_stale_prod: assert property (@(posedge clk) disable iff (!arst_n)
		prod_vld_s1 |-> !cmd.load)
		else $error("product pending at accept");

endmodule

// ===== rtl/core/all_pole_feedback_filter.sv =====
// ----------------------------------------------------------------------------
// all_pole_feedback_filter
// All-pole IIR filter: y = x + sum of coeff_k * y[n-k], Q2.16 coefficients,
// rounded and saturated to the sample width, one shared multiplier.
// Steps per item: the accept cycle, one multiply per tap in use (1..6), a drain
// step and a finish step that writes the output register; a held output
// register stalls the finish. A new item is taken only after the finish.
// Reset clears history, write position, coefficients (0) and tap count (1).
// ----------------------------------------------------------------------------
module all_pole_feedback_filter
	import apf_pkg::*;
#(
	parameter int MAX_TAPS     = 6,
	parameter int SAMPLE_WIDTH = 24
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_write,
	input  logic [CFG_IDX_W-1:0]           cfg_index,
	input  logic [CFG_DATA_W-1:0]          cfg_data,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic signed [SAMPLE_WIDTH-1:0] sample_in,
	input  logic                           clear,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic signed [SAMPLE_WIDTH-1:0] filtered_sample,
	output logic                           overflow
);

	cmd_t cmd;
	sts_t sts;

	// Sequencer.
	apf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Arithmetic, storage and output register.
	apf_datapath #(
		.MAX_TAPS     (MAX_TAPS),
		.SAMPLE_WIDTH (SAMPLE_WIDTH)
	) u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_write       (cfg_write),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.sample_in       (sample_in),
		.clear           (clear),
		.cmd             (cmd),
		.sts             (sts),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.filtered_sample (filtered_sample),
		.overflow        (overflow)
	);

endmodule

// ===== tb/sv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for the all-pole feedback filter. A driver feeds
// samples from a queue over the valid/ready input and a monitor checks every
// output item against a behavioral model of the filter, which is kept in step
// with the configuration writes. A short directed part covers extremes,
// rounding ties, saturation, clear and the tap-count corner values. Random
// phases follow, each with new coefficients, most with new taps, and idling on
// both sides outside quiet phases and long output stalls that back up input.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import apf_pkg::*;

	localparam int SW           = 24;
	localparam int NTAPS        = 6;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int TAIL_CYCLES  = 24;
	localparam int HOLD_LEN     = 200;
	localparam int RAND_PHASES  = 24;
	localparam int PHASE_ITEMS  = 77;
	localparam int MAX_REPORTS  = 200;

	localparam longint SAT_HI = (longint'(1) <<< (SW - 1)) - 1;
	localparam longint SAT_LO = -SAT_HI - 1;
	localparam logic signed [SW-1:0] SMPL_MAX = {1'b0, {(SW - 1){1'b1}}};
	localparam logic signed [SW-1:0] SMPL_MIN = {1'b1, {(SW - 1){1'b0}}};
	localparam logic [CFG_DATA_W-1:0] COEFF_MAX = {1'b0, {(COEFF_W - 1){1'b1}}};
	localparam logic [CFG_DATA_W-1:0] COEFF_MIN = {1'b1, {(COEFF_W - 1){1'b0}}};
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

	typedef struct {
		logic signed [SW-1:0] sample;
		logic                 clr;
	} sample_item_t;

	typedef struct {
		logic signed [SW-1:0] y;
		logic                 ovf;
	} filter_out_t;

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_write;
	logic [CFG_IDX_W-1:0]   cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;
	logic                   in_valid;
	logic                   in_ready;
	logic signed [SW-1:0]   sample_in;
	logic                   clear;
	logic                   out_valid;
	logic                   out_ready;
	logic signed [SW-1:0]   filtered_sample;
	logic                   overflow;

	all_pole_feedback_filter #(
		.MAX_TAPS     (NTAPS),
		.SAMPLE_WIDTH (SW)
	) uut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_write       (cfg_write),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.sample_in       (sample_in),
		.clear           (clear),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.filtered_sample (filtered_sample),
		.overflow        (overflow)
	);

	// Model state: tap register, coefficients, output history, write position.
	logic [TAPS_W-1:0]           tap_reg;
	logic signed [COEFF_W-1:0]   coeff_q [1:NTAPS];
	logic signed [SW-1:0]        y_hist [0:NTAPS-1];
	int unsigned                 wr_pos;

	sample_item_t sample_queue[$];
	filter_out_t  expected_outputs[$];

	sample_item_t cur_item;
	filter_out_t  got_exp;
	bit  quiet_phase = 1'b0;
	bit  in_taken = 1'b0;
	bit  out_taken = 1'b0;
	int  tx_gap = 0;
	int  rx_wait = 0;
	int  rx_hold = 0;
	int  out_count = 0;
	int  errors = 0;
	int  cycles = 0;

	// Clock.
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Cycle limit in case the block hangs.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	function automatic void flush_history();
		for (int i = 0; i < NTAPS; i++)
			y_hist[i] = '0;
		wr_pos = 0;
	endfunction

	// Computes the output for one sample and advances the model history.
	function automatic filter_out_t predict_output(input sample_item_t it);
		int unsigned t;
		int unsigned j;
		longint acc;
		longint y;
		filter_out_t r;
		t = (tap_reg == 0) ? 1 : (tap_reg > NTAPS) ? NTAPS : tap_reg;
		if (it.clr)
			flush_history();
		if (wr_pos >= t)
			wr_pos = 0;
		acc = longint'(it.sample) * (longint'(1) <<< FRAC_BITS);
		j = wr_pos;
		for (int k = 0; k < t; k++) begin
			acc += longint'(coeff_q[k + 1]) * longint'(y_hist[j]);
			j = (j == 0) ? t - 1 : j - 1;
		end
		// Round half up, then clamp to the sample range.
		y = (acc + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
		r.ovf = 1'b0;
		if (y > SAT_HI) begin
			y = SAT_HI;
			r.ovf = 1'b1;
		end
		if (y < SAT_LO) begin
			y = SAT_LO;
			r.ovf = 1'b1;
		end
		r.y = y[SW-1:0];
		wr_pos = (wr_pos + 1 >= t) ? 0 : wr_pos + 1;
		y_hist[wr_pos] = r.y;
		return r;
	endfunction

	// One register write; the block is idle whenever this is called.
	task automatic reg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		if (idx == REG_TAPS) begin
			tap_reg = val[TAPS_W-1:0];
			flush_history();
		end else if (idx >= REG_COEFF_1 && idx < REG_COEFF_1 + NTAPS) begin
			coeff_q[idx - REG_COEFF_1 + 1] = val;
		end
		@(negedge clk);
		cfg_write <= 1'b0;
	endtask

	task automatic add_item(input logic signed [SW-1:0] s, input logic c);
		sample_item_t it;
		it.sample = s;
		it.clr = c;
		sample_queue.push_back(it);
	endtask

	// Waits until every queued sample went in and every output came back.
	task automatic wait_idle();
		while (sample_queue.size() != 0 || in_valid || expected_outputs.size() != 0)
			@(negedge clk);
		repeat (TAIL_CYCLES) @(negedge clk);
	endtask

	function automatic logic signed [SW-1:0] rand_sample();
		case ($urandom_range(0, 4))
			0, 1: return SW'($urandom);
			2: return SW'($urandom_range(0, 1023) - 512);
			3: return SW'($urandom_range(0, 65535) - 32768);
			default: return $urandom_range(0, 1) ? SMPL_MAX : SMPL_MIN;
		endcase
	endfunction

	// Style 0: any value, 1: small and stable, 2: the two extremes.
	function automatic logic [CFG_DATA_W-1:0] rand_coeff(input int style);
		case (style)
			0: return CFG_DATA_W'($urandom);
			1: return CFG_DATA_W'($urandom_range(0, 16383) - 8192);
			default: return $urandom_range(0, 1) ? COEFF_MAX : COEFF_MIN;
		endcase
	endfunction

	// Input side: record each accepted item and predict its output.
	always @(posedge clk) begin
		in_taken <= arst_n && in_valid && in_ready;
		out_taken <= arst_n && out_valid && out_ready;
		if (arst_n && in_valid && in_ready) begin
			cur_item.sample = sample_in;
			cur_item.clr = clear;
			expected_outputs.push_back(predict_output(cur_item));
		end
		// Output side: compare each accepted item with the oldest prediction.
		if (arst_n && out_valid && out_ready) begin
			out_count++;
			if (expected_outputs.size() == 0) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("%0t: unexpected output item: sample %0d overflow %0b",
						$time, filtered_sample, overflow);
			end else begin
				got_exp = expected_outputs.pop_front();
				if (filtered_sample !== got_exp.y) begin
					errors++;
					if (errors <= MAX_REPORTS)
						$display("%0t: filtered_sample expected %0d actual %0d",
							$time, got_exp.y, filtered_sample);
				end
				if (overflow !== got_exp.ovf) begin
					errors++;
					if (errors <= MAX_REPORTS)
						$display("%0t: overflow expected %0b actual %0b",
							$time, got_exp.ovf, overflow);
				end
			end
		end
	end

	// Sender: holds an item until accepted, then idles for its drawn gap.
	always @(negedge clk) begin
		if (!arst_n || (in_valid && !in_taken)) begin
		end else if (tx_gap > 0) begin
			tx_gap--;
			in_valid <= 1'b0;
		end else if (sample_queue.size() > 0) begin
			cur_item = sample_queue.pop_front();
			sample_in <= cur_item.sample;
			clear <= cur_item.clr;
			in_valid <= 1'b1;
			tx_gap = quiet_phase ? 0 : $urandom_range(0, 3);
		end else begin
			in_valid <= 1'b0;
		end
	end

	// Receiver: random stall after each item, plus two long holds that let
	// the block back up while the sender keeps offering.
	always @(negedge clk) begin
		if (out_taken) begin
			rx_wait = quiet_phase ? 0 : $urandom_range(0, 3);
			if (out_count == 500 || out_count == 1400)
				rx_hold = HOLD_LEN;
		end
		if (rx_hold > 0) begin
			rx_hold--;
			out_ready <= 1'b0;
		end else if (rx_wait > 0) begin
			rx_wait--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// Stimulus.
	initial begin
		int style;
		int ph_taps;
		arst_n = 1'b0;
		cfg_write = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		sample_in = '0;
		clear = 1'b0;
		out_ready = 1'b0;
		tap_reg = TAPS_W'(1);
		for (int k = 1; k <= NTAPS; k++)
			coeff_q[k] = '0;
		flush_history();
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Reset configuration passes samples straight through.
		add_item(SMPL_MAX, 1'b0);
		add_item(SMPL_MIN, 1'b0);
		add_item('0, 1'b0);
		add_item(SW'(-1), 1'b0);
		add_item(SW'(1), 1'b0);
		wait_idle();

		// Half coefficient on one tap gives rounding ties of both signs.
		reg_write(REG_COEFF_1, 18'd32768);
		add_item(SW'(1), 1'b0);
		add_item('0, 1'b0);
		add_item(SW'(-1), 1'b1);
		add_item('0, 1'b0);
		wait_idle();

		// Extreme coefficients drive the sum into both saturation limits.
		reg_write(REG_TAPS, CFG_DATA_W'(2));
		reg_write(REG_COEFF_1, COEFF_MAX);
		reg_write(CFG_IDX_W'(REG_COEFF_1 + 1), COEFF_MIN);
		add_item(SMPL_MAX, 1'b0);
		add_item(SMPL_MAX, 1'b0);
		add_item(SMPL_MIN, 1'b0);
		add_item(SMPL_MIN, 1'b0);
		add_item(SMPL_MIN, 1'b0);
		add_item(SMPL_MAX, 1'b1);
		wait_idle();

		// A tap count above the maximum acts as the maximum.
		reg_write(REG_TAPS, CFG_DATA_W'(7));
		reg_write(CFG_IDX_W'(REG_COEFF_1 + 2), COEFF_MAX);
		reg_write(CFG_IDX_W'(REG_COEFF_1 + 3), COEFF_MIN);
		reg_write(CFG_IDX_W'(REG_COEFF_1 + 4), 18'd16384);
		reg_write(CFG_IDX_W'(REG_COEFF_1 + 5), COEFF_MAX);
		add_item(SMPL_MAX, 1'b0);
		add_item(SW'(12345), 1'b0);
		add_item(SMPL_MIN, 1'b0);
		add_item(SW'(-777), 1'b0);
		wait_idle();

		// A tap count of zero acts as one; the unused index changes nothing.
		reg_write(REG_TAPS, CFG_DATA_W'(0));
		reg_write(REG_COEFF_1, COEFF_MIN);
		reg_write(REG_UNUSED, '1);
		add_item(SW'(100000), 1'b0);
		add_item('0, 1'b0);
		add_item(SW'(-5), 1'b0);
		wait_idle();

		// Random phases. Every third phase only changes coefficients, so the
		// history carries over from the phase before.
		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			style = $urandom_range(0, 3);
			quiet_phase = (ph % 4 == 0);
			if (ph % 3 != 2) begin
				ph_taps = (ph == 0) ? NTAPS : (ph == 1) ? 1 : $urandom_range(0, 7);
				reg_write(REG_TAPS, CFG_DATA_W'(ph_taps));
			end
			for (int k = 0; k < NTAPS; k++)
				if (ph < 2 || $urandom_range(0, 2) != 0)
					reg_write(CFG_IDX_W'(REG_COEFF_1 + k),
						rand_coeff(style == 3 ? $urandom_range(0, 2) : style));
			if (ph % 5 == 0)
				reg_write(REG_UNUSED, CFG_DATA_W'($urandom));
			for (int n = 0; n < PHASE_ITEMS; n++)
				add_item(rand_sample(), $urandom_range(0, 15) == 0);
			wait_idle();
		end

		if (errors == 0 && expected_outputs.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
